[rtl/h264qmf_pkg.sv]
// Package: item types, widths and scale tables for the H.264 multiplication factor block.
package h264qmf_pkg;

    localparam int QP_W    = 6;
    localparam int POS_W   = 6;
    localparam int WGT_W   = 8;
    localparam int MF_W    = 16;
    localparam int FRAC    = 22;
    localparam int NUM_W   = FRAC + 1;
    localparam int SCALE_W = 15;
    localparam int SC16_W  = SCALE_W + 4;
    localparam int PROD_W  = SC16_W + NUM_W;
    localparam int RAW_W   = PROD_W - FRAC;
    localparam int SHF_W   = RAW_W + 1;
    localparam int RSH_W   = 4;

    typedef struct packed {
        logic [QP_W-1:0]  qp;
        logic             block_8x8;
        logic [POS_W-1:0] position;
        logic [WGT_W-1:0] weight;
    } in_t;

    typedef struct packed {
        logic [MF_W-1:0] mult_factor;
        logic            saturated;
    } out_t;

    // Controls for the final shift and clamp.
    typedef struct packed {
        logic             zero;
        logic             shl;
        logic [RSH_W-1:0] rsh;
    } post_t;

    typedef struct packed {
        logic [WGT_W-1:0]   weight;
        logic [SCALE_W-1:0] scale;
        post_t              post;
    } side_t;

    // One division step's payload.
    typedef struct packed {
        logic [WGT_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        side_t            side;
    } div_t;

    // qp / 6 by reciprocal multiply, exact for every 6-bit qp.
    function automatic logic [RSH_W-1:0] qp_div6(input logic [QP_W-1:0] qp);
        logic [11:0] p;
        p = {6'b0, qp} * 12'd43;
        return p[11:8];
    endfunction

    function automatic logic [2:0] qp_mod6(input logic [QP_W-1:0] qp,
                                           input logic [RSH_W-1:0] q);
        logic [QP_W-1:0] m;
        m = qp - QP_W'({2'b0, q} * 6'd6);
        return m[2:0];
    endfunction

    function automatic logic [2:0] class8(input logic [3:0] idx);
        unique case (idx)
            4'd0:  return 3'd0;
            4'd1:  return 3'd3;
            4'd2:  return 3'd4;
            4'd3:  return 3'd3;
            4'd4:  return 3'd3;
            4'd5:  return 3'd1;
            4'd6:  return 3'd5;
            4'd7:  return 3'd1;
            4'd8:  return 3'd4;
            4'd9:  return 3'd5;
            4'd10: return 3'd2;
            4'd11: return 3'd5;
            4'd12: return 3'd3;
            4'd13: return 3'd1;
            4'd14: return 3'd5;
            4'd15: return 3'd1;
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] scale4(input logic [2:0] row,
                                                  input logic [1:0] cls);
        logic [SCALE_W-1:0] a, b, c;
        unique case (row)
            3'd0:    begin a = 15'd13107; b = 15'd8066; c = 15'd5243; end
            3'd1:    begin a = 15'd11916; b = 15'd7490; c = 15'd4660; end
            3'd2:    begin a = 15'd10082; b = 15'd6554; c = 15'd4194; end
            3'd3:    begin a = 15'd9362;  b = 15'd5825; c = 15'd3647; end
            3'd4:    begin a = 15'd8192;  b = 15'd5243; c = 15'd3355; end
            default: begin a = 15'd7282;  b = 15'd4559; c = 15'd2893; end
        endcase
        unique case (cls)
            2'd0:    return a;
            2'd1:    return b;
            default: return c;
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] scale8(input logic [2:0] row,
                                                  input logic [2:0] cls);
        logic [SCALE_W-1:0] v [6];
        unique case (row)
            3'd0:    v = '{15'd13107, 15'd11428, 15'd20972, 15'd12222, 15'd16777, 15'd15481};
            3'd1:    v = '{15'd11916, 15'd10826, 15'd19174, 15'd11058, 15'd14980, 15'd14290};
            3'd2:    v = '{15'd10082, 15'd8943,  15'd15978, 15'd9675,  15'd12710, 15'd11985};
            3'd3:    v = '{15'd9362,  15'd8228,  15'd14913, 15'd8931,  15'd11984, 15'd11259};
            3'd4:    v = '{15'd8192,  15'd7346,  15'd13159, 15'd7740,  15'd10486, 15'd9777};
            default: v = '{15'd7282,  15'd6428,  15'd11570, 15'd6830,  15'd9118,  15'd8640};
        endcase
        unique case (cls)
            3'd0:    return v[0];
            3'd1:    return v[1];
            3'd2:    return v[2];
            3'd3:    return v[3];
            3'd4:    return v[4];
            default: return v[5];
        endcase
    endfunction

endpackage

[rtl/h264_quant_mf_from_weight.sv]
// Top level: H.264 quantizer multiplication factor from QP, block size, position and weight.
//
// Takes one item per cycle and returns one result per item, in order. An item
// passes 23 division cells (one quotient bit of round(2^22/weight) per cell),
// then a multiply stage, a rounding stage and the output register that drives
// m_valid. The rate stays one item per cycle, each stage holding one item and
// advancing whenever the stage after it is empty or moving. Stages drain into
// bubbles, so s_ready stays high while a result waits on m_ready until every
// stage is full. A zero weight gives 65535 with saturated set; any factor above
// 65535 is clamped the same way. No state survives between items and reset only
// empties the pipeline.
module h264_quant_mf_from_weight (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  h264qmf_pkg::in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output h264qmf_pkg::out_t  m_data
);

    localparam int NW = h264qmf_pkg::NUM_W;

    // Front end: table lookups feed the first cell directly.
    logic [h264qmf_pkg::RSH_W-1:0]   qdiv;
    logic [2:0]                      row;
    logic [1:0]                      cls4;
    h264qmf_pkg::div_t               front;

    always_comb begin
        qdiv = h264qmf_pkg::qp_div6(s_data.qp);
        row  = h264qmf_pkg::qp_mod6(s_data.qp, qdiv);
        cls4 = {1'b0, s_data.position[0]} + {1'b0, s_data.position[2]};
        front.rem         = '0;
        front.quo         = '0;
        front.num         = {1'b1, {(NW - h264qmf_pkg::WGT_W){1'b0}},
                             s_data.weight[h264qmf_pkg::WGT_W-1:1]};
        front.side.weight = s_data.weight;
        front.side.post.zero = (s_data.weight == '0);
        if (s_data.block_8x8) begin
            front.side.scale    = h264qmf_pkg::scale8(row,
                h264qmf_pkg::class8({s_data.position[4:3], s_data.position[1:0]}));
            front.side.post.shl = 1'b0;
            front.side.post.rsh = qdiv;
        end else begin
            front.side.scale    = h264qmf_pkg::scale4(row, cls4);
            // count qp/6-1: below zero means one left shift
            front.side.post.shl = (qdiv == '0);
            front.side.post.rsh = (qdiv == '0) ? '0 : qdiv - 4'd1;
        end
    end

    // Division chain: cell k resolves numerator bit NW-1-k.
    logic              cell_valid [NW+1];
    logic              cell_ready [NW+1];
    h264qmf_pkg::div_t cell_data  [NW+1];

    assign cell_valid[0] = s_valid;
    assign cell_data[0]  = front;
    assign s_ready       = cell_ready[0];

    for (genvar k = 0; k < NW; k++) begin : g_cell
        h264qmf_div_cell #(
            .BIT(NW - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[k]),
            .in_ready  (cell_ready[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_ready (cell_ready[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // Multiply, round and output stages.
    logic                             mul_valid_reg;
    logic [h264qmf_pkg::PROD_W-1:0]   prod_reg;
    logic [h264qmf_pkg::PROD_W-1:0]   prod_next;
    h264qmf_pkg::post_t               mul_post_reg;
    logic                             mul_ready;

    logic                             rnd_valid_reg;
    logic [h264qmf_pkg::RAW_W-1:0]    raw_reg;
    logic [h264qmf_pkg::RAW_W-1:0]    raw_next;
    logic [h264qmf_pkg::PROD_W-1:0]   rnd_sum;
    h264qmf_pkg::post_t               rnd_post_reg;
    logic                             rnd_ready;

    logic                             m_valid_reg;
    h264qmf_pkg::out_t                out_reg;
    h264qmf_pkg::out_t                out_next;
    logic                             out_ready;
    logic [h264qmf_pkg::SHF_W-1:0]    shifted;
    logic [h264qmf_pkg::SHF_W-1:0]    rsum;
    logic [h264qmf_pkg::RSH_W-1:0]    rsh_m1;

    assign out_ready     = !m_valid_reg || m_ready;
    assign rnd_ready     = !rnd_valid_reg || out_ready;
    assign mul_ready     = !mul_valid_reg || rnd_ready;
    assign cell_ready[NW] = mul_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // scale * 16 * reciprocal
    assign prod_next = {cell_data[NW].side.scale, 4'b0} * cell_data[NW].quo;

    // drop the fraction with rounding
    assign rnd_sum  = prod_reg + (h264qmf_pkg::PROD_W'(1) << (h264qmf_pkg::FRAC - 1));
    assign raw_next = rnd_sum[h264qmf_pkg::PROD_W-1:h264qmf_pkg::FRAC];

    always_comb begin
        rsh_m1 = rnd_post_reg.rsh - 4'd1;
        rsum   = {1'b0, raw_reg} + (h264qmf_pkg::SHF_W'(1) << rsh_m1);
        if (rnd_post_reg.shl) begin
            shifted = {raw_reg, 1'b0};
        end else if (rnd_post_reg.rsh == '0) begin
            shifted = {1'b0, raw_reg};
        end else begin
            shifted = rsum >> rnd_post_reg.rsh;
        end
        // clamp on overflow or zero weight
        if (rnd_post_reg.zero || (shifted[h264qmf_pkg::SHF_W-1:h264qmf_pkg::MF_W] != '0)) begin
            out_next.mult_factor = '1;
            out_next.saturated   = 1'b1;
        end else begin
            out_next.mult_factor = shifted[h264qmf_pkg::MF_W-1:0];
            out_next.saturated   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_valid_reg <= cell_valid[NW];
            end
            if (rnd_ready) begin
                rnd_valid_reg <= mul_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= rnd_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && cell_valid[NW]) begin
            prod_reg     <= prod_next;
            mul_post_reg <= cell_data[NW].side.post;
        end
        if (rnd_ready && mul_valid_reg) begin
            raw_reg      <= raw_next;
            rnd_post_reg <= mul_post_reg;
        end
        if (out_ready && rnd_valid_reg) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // Input backpressure only when the whole chain is full behind a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled output");

    // Pipeline comes out of reset empty.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A clamped result always carries the ceiling value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.saturated) |-> (m_data.mult_factor == 16'hFFFF))
        else $error("saturated result below ceiling");

    // A held result stays put until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("stalled result changed");
`endif

endmodule

[rtl/h264qmf_div_cell.sv]
// One restoring-division cell: resolves a single quotient bit and passes the item on.
module h264qmf_div_cell #(
    parameter int BIT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  h264qmf_pkg::div_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output h264qmf_pkg::div_t   out_data
);

    logic              valid_reg;
    h264qmf_pkg::div_t data_reg;
    h264qmf_pkg::div_t data_next;
    logic [h264qmf_pkg::WGT_W:0] trial;
    logic [h264qmf_pkg::WGT_W:0] diff;
    logic                        ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        trial = {in_data.rem, in_data.num[BIT]};
        diff  = trial - {1'b0, in_data.side.weight};
        ge    = trial >= {1'b0, in_data.side.weight};
        data_next      = in_data;
        data_next.rem  = ge ? diff[h264qmf_pkg::WGT_W-1:0] : trial[h264qmf_pkg::WGT_W-1:0];
        data_next.quo  = {in_data.quo[h264qmf_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[tb/h264_quant_mf_from_weight_test.sv]
// Testbench for the H.264 multiplication factor block: items checked against a predictor.
module h264_quant_mf_from_weight_test;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    h264qmf_pkg::in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    h264qmf_pkg::out_t m_data;

    h264_quant_mf_from_weight i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Base scales per QP row: 4x4 by class 0..2, 8x8 by class 0..5.
    int unsigned scale4_lut [6][3] = '{
        '{13107, 8066, 5243},
        '{11916, 7490, 4660},
        '{10082, 6554, 4194},
        '{ 9362, 5825, 3647},
        '{ 8192, 5243, 3355},
        '{ 7282, 4559, 2893}
    };
    int unsigned scale8_lut [6][6] = '{
        '{13107, 11428, 20972, 12222, 16777, 15481},
        '{11916, 10826, 19174, 11058, 14980, 14290},
        '{10082,  8943, 15978,  9675, 12710, 11985},
        '{ 9362,  8228, 14913,  8931, 11984, 11259},
        '{ 8192,  7346, 13159,  7740, 10486,  9777},
        '{ 7282,  6428, 11570,  6830,  9118,  8640}
    };
    // 8x8 scan position (4 bits) to scale class.
    int unsigned class8_lut [16] = '{0, 3, 4, 3, 3, 1, 5, 1, 4, 5, 2, 5, 3, 1, 5, 1};

    h264qmf_pkg::in_t  item_q [$];     // items waiting to be offered
    h264qmf_pkg::out_t mf_exp_q [$];   // factors expected, oldest first
    int                err_cnt = 0;

    // Compute the factor that one item must produce.
    function automatic h264qmf_pkg::out_t mf_predict(input h264qmf_pkg::in_t it);
        int unsigned       row;
        int unsigned       idx;
        int unsigned       cls;
        int                sh;
        longint unsigned   scl;
        longint unsigned   rcp;
        longint unsigned   mf;
        h264qmf_pkg::out_t r;
        r.mult_factor = 16'hFFFF;
        r.saturated   = 1'b1;
        if (it.weight == '0) begin
            return r;
        end
        row = it.qp % 6;
        if (it.block_8x8) begin
            idx = {it.position[4:3], it.position[1:0]};
            scl = scale8_lut[row][class8_lut[idx]];
            sh  = int'(it.qp / 6);
        end else begin
            cls = int'(it.position[0]) + int'(it.position[2]);
            scl = scale4_lut[row][cls];
            sh  = int'(it.qp / 6) - 1;
        end
        // Round 2^22 / weight to nearest, then scale and drop the fraction.
        rcp = ((64'd1 << 22) + (it.weight >> 1)) / it.weight;
        mf  = (scl * 16 * rcp + (64'd1 << 21)) >> 22;
        if (sh <= 0) begin
            mf = mf << (-sh);
        end else begin
            mf = (mf + (64'd1 << (sh - 1))) >> sh;
        end
        if (mf <= 64'd65535) begin
            r.mult_factor = mf[15:0];
            r.saturated   = 1'b0;
        end
        return r;
    endfunction

    // Draw one item; favor legal QP and nonzero weight, keep the odd corners alive.
    function automatic h264qmf_pkg::in_t mf_random_item();
        h264qmf_pkg::in_t it;
        int               pick;
        it.block_8x8 = 1'($urandom_range(0, 1));
        it.position  = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 75)      it.qp = 6'($urandom_range(0, 51));
        else if (pick < 88) it.qp = 6'($urandom_range(52, 63));
        else                it.qp = 6'($urandom_range(0, 5));
        pick = $urandom_range(0, 99);
        if (pick < 80)      it.weight = 8'($urandom_range(1, 255));
        else if (pick < 95) it.weight = 8'($urandom_range(1, 4));
        else                it.weight = '0;
        return it;
    endfunction

    task automatic queue_item(input logic [5:0] qp, input logic blk,
                              input logic [5:0] pos, input logic [7:0] w);
        h264qmf_pkg::in_t it;
        it.qp        = qp;
        it.block_8x8 = blk;
        it.position  = pos;
        it.weight    = w;
        item_q.push_back(it);
    endtask

    // Clock and the single reset pulse.
    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Sender: offer items in bursts of random length, separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            // Record what the block just took.
            if (s_valid && s_ready) begin
                mf_exp_q.push_back(mf_predict(s_data));
            end
            // Hold the offered item until it is taken.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    s_data  <= item_q.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        // Leave a third of the bursts back to back.
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result, then pick the next ready from a changing stall mode.
    int rx_count  = 0;
    int rdy_mode  = 0;
    int rdy_left  = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        h264qmf_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_count++;
                if (mf_exp_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, got mult_factor %0d sat %0b",
                             $time, m_data.mult_factor, m_data.saturated);
                end else begin
                    want = mf_exp_q.pop_front();
                    if (m_data.mult_factor !== want.mult_factor) begin
                        err_cnt++;
                        $display("%0t: mult_factor expected %0d got %0d",
                                 $time, want.mult_factor, m_data.mult_factor);
                    end
                    if (m_data.saturated !== want.saturated) begin
                        err_cnt++;
                        $display("%0t: saturated expected %0b got %0b",
                                 $time, want.saturated, m_data.saturated);
                    end
                end
            end
            // Once, well into the random part, hold off long enough to fill the pipeline.
            if (!hold_done && rx_count == 300) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (rdy_left <= 0) begin
                rdy_mode = $urandom_range(0, 3);
                rdy_left = $urandom_range(20, 200);
            end
            rdy_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rdy_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stimulus: directed corners, a full drain, then the random bulk.
    initial begin
        while (!aresetn) @(posedge aclk);

        queue_item(6'd0,  1'b0, 6'd0,  8'd1);    // 4x4 left shift, saturates
        queue_item(6'd0,  1'b0, 6'd5,  8'd255);
        queue_item(6'd5,  1'b0, 6'd15, 8'd16);   // 4x4 count of -1
        queue_item(6'd6,  1'b0, 6'd0,  8'd16);   // 4x4 count of zero
        queue_item(6'd51, 1'b0, 6'd10, 8'd255);
        queue_item(6'd51, 1'b1, 6'd63, 8'd1);
        queue_item(6'd0,  1'b1, 6'd0,  8'd1);    // 8x8 count of zero, overflow
        queue_item(6'd0,  1'b1, 6'd18, 8'd1);    // largest 8x8 scale
        queue_item(6'd52, 1'b1, 6'd18, 8'd1);    // QP past 51
        queue_item(6'd63, 1'b1, 6'd63, 8'd255);  // deepest right shift
        queue_item(6'd63, 1'b0, 6'd63, 8'd1);
        queue_item(6'd57, 1'b0, 6'd3,  8'd128);
        queue_item(6'd20, 1'b0, 6'd7,  8'd0);    // zero weight
        queue_item(6'd63, 1'b1, 6'd0,  8'd0);
        queue_item(6'd12, 1'b1, 6'd36, 8'd255);
        queue_item(6'd30, 1'b0, 6'd1,  8'd2);
        queue_item(6'd44, 1'b1, 6'd45, 8'd3);
        queue_item(6'd1,  1'b1, 6'd6,  8'd17);
        queue_item(6'd2,  1'b0, 6'd4,  8'd1);
        queue_item(6'd3,  1'b1, 6'd27, 8'd200);
        queue_item(6'd4,  1'b0, 6'd48, 8'd9);    // upper position bits ignored for 4x4
        queue_item(6'd42, 1'b1, 6'd9,  8'd64);
        queue_item(6'd33, 1'b1, 6'd42, 8'd170);
        queue_item(6'd27, 1'b0, 6'd42, 8'd85);

        // Pause the sender until every result is back.
        while (item_q.size() != 0 || s_valid || mf_exp_q.size() != 0) @(posedge aclk);

        for (int n = 0; n < 1500; n++) begin
            item_q.push_back(mf_random_item());
        end

        while (item_q.size() != 0 || s_valid || mf_exp_q.size() != 0) @(posedge aclk);
        // Let the pipeline settle so a stray result still shows up.
        repeat (40) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Abort a hung run.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[h264_quant_mf_from_weight.f]
rtl/h264qmf_pkg.sv
rtl/h264qmf_div_cell.sv
rtl/h264_quant_mf_from_weight.sv
tb/h264_quant_mf_from_weight_test.sv
